FILE: rtl/tiu_pkg.sv
`default_nettype none
package tiu_pkg;

  localparam int INDEX_BITS = 48;
  localparam int OUT_BITS   = 25;
  // radicand is 8*p+1, padded to an even width
  localparam int RAD_BITS   = ((INDEX_BITS + 3 + 1) / 2) * 2;
  localparam int ROOT_BITS  = RAD_BITS / 2;
  localparam int REM_BITS   = ROOT_BITS + 2;

  typedef struct packed {
    logic                 valid;
    logic [RAD_BITS-1:0]  rad;
    logic [REM_BITS-1:0]  rem;
    logic [ROOT_BITS-1:0] root;
  } tiu_lane_t;

endpackage
`default_nettype wire

FILE: rtl/tiu_sqrt_stage.sv
`default_nettype none
module tiu_sqrt_stage import tiu_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      en,
  input  wire tiu_lane_t d,
  output tiu_lane_t      q
);

  tiu_lane_t           q_r;
  tiu_lane_t           q_nxt;
  logic [REM_BITS-1:0] rem_sh;
  logic [REM_BITS-1:0] trial;
  logic                ge;

  // one restoring square-root digit
  always_comb begin
    rem_sh      = {d.rem[REM_BITS-3:0], d.rad[RAD_BITS-1 -: 2]};
    trial       = {d.root, 2'b01};
    ge          = (rem_sh >= trial);
    q_nxt.valid = d.valid;
    q_nxt.rad   = d.rad << 2;
    q_nxt.rem   = ge ? (rem_sh - trial) : rem_sh;
    q_nxt.root  = {d.root[ROOT_BITS-2:0], ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r.valid <= q_nxt.valid;
    end
    if (en) begin
      q_r.rad  <= q_nxt.rad;
      q_r.rem  <= q_nxt.rem;
      q_r.root <= q_nxt.root;
    end
  end

  assign q = q_r;

endmodule
`default_nettype wire

FILE: rtl/tiu_finish.sv
`default_nettype none
module tiu_finish import tiu_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                en,
  input  wire tiu_lane_t           d,
  output logic                     out_valid,
  output logic [OUT_BITS-1:0]      out_row,
  output logic [OUT_BITS-1:0]      out_column
);

  logic                  valid_r;
  logic [OUT_BITS-1:0]   row_r;
  logic [OUT_BITS-1:0]   column_r;
  logic [OUT_BITS-1:0]   row_nxt;
  logic [OUT_BITS-1:0]   column_nxt;
  logic [ROOT_BITS-1:0]  s_m1;
  logic [REM_BITS:0]     adj;

  // s = isqrt(8p+1), i = (s-1)/2; j = r/8 for odd s, (r+2s-1)/8 for even s
  always_comb begin
    s_m1       = d.root - ROOT_BITS'(1);
    adj        = {1'b0, d.rem} + (REM_BITS + 1)'({d.root, 1'b0}) - (REM_BITS + 1)'(1);
    row_nxt    = OUT_BITS'(s_m1 >> 1);
    column_nxt = d.root[0] ? OUT_BITS'(d.rem >> 3) : OUT_BITS'(adj >> 3);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= d.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      row_r    <= row_nxt;
      column_r <= column_nxt;
    end
  end

  assign out_valid  = valid_r;
  assign out_row    = row_r;
  assign out_column = column_r;

endmodule
`default_nettype wire

FILE: rtl/triangular_index_unpack.sv
// Pipeline: 27 registers, one per root bit of isqrt(8p+1) (26 stages) plus the
//   output register, the first loaded at the transfer edge; a result is valid
//   once its index has passed through all of them.
// Throughput: one index per cycle; the whole pipeline holds while a result
//   waits on out_ready.
// Reset: synchronous, active low; clears the stage and output valid bits only.
`default_nettype none
module triangular_index_unpack import tiu_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [INDEX_BITS-1:0] in_packed_index,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [OUT_BITS-1:0]        out_row,
  output logic [OUT_BITS-1:0]        out_column
);

  logic      en;
  tiu_lane_t lane [ROOT_BITS+1];

  assign en       = !out_valid || out_ready;
  assign in_ready = en;

  always_comb begin
    lane[0].valid = in_valid;
    lane[0].rad   = RAD_BITS'({in_packed_index, 3'b001});
    lane[0].rem   = '0;
    lane[0].root  = '0;
  end

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    tiu_sqrt_stage u_stage (
      .clk   (clk),
      .rst_n (rst_n),
      .en    (en),
      .d     (lane[k]),
      .q     (lane[k+1])
    );
  end

  tiu_finish u_finish (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (en),
    .d          (lane[ROOT_BITS]),
    .out_valid  (out_valid),
    .out_row    (out_row),
    .out_column (out_column)
  );

endmodule
`default_nettype wire

FILE: rtl/tiu_checker.sv
`default_nettype none
module tiu_checker import tiu_pkg::*; (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_ready,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire logic [OUT_BITS-1:0] out_row,
  input wire logic [OUT_BITS-1:0] out_column
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_col_le_row: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_column <= out_row))
    else $error("column above row");

  a_stall_in: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |-> !in_ready)
    else $error("input taken while result stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_row) && $stable(out_column)))
    else $error("stalled result changed");

endmodule

bind triangular_index_unpack tiu_checker u_tiu_checker (.*);
`default_nettype wire

FILE: tb/tb_triangular_index_unpack.sv
`timescale 1ns / 1ps

module tb_triangular_index_unpack;
  import tiu_pkg::*;

  localparam logic [INDEX_BITS-1:0] INDEX_MAX = '1;
  localparam longint unsigned ROW_MAX = 64'd23726565;

  typedef struct packed {
    logic [INDEX_BITS-1:0] index;
    logic [OUT_BITS-1:0]   row;
    logic [OUT_BITS-1:0]   column;
  } coord_t;

  class index_unpack_checker;
    coord_t      expected_coords[$];
    int unsigned errors;
    int unsigned indexes_seen;
    int unsigned coords_checked;

    // row = largest r with r*(r+1) <= 2p, searched one bit at a time
    function coord_t split_index(logic [INDEX_BITS-1:0] p);
      logic [63:0]  idx;
      logic [63:0]  r;
      logic [63:0]  c;
      logic [127:0] prod;
      logic [127:0] tri_r;
      coord_t       res;
      idx = 64'(p);
      r = 64'd0;
      for (int b = 32; b >= 0; b--) begin
        c = r | (64'd1 << b);
        prod = 128'(c) * 128'(c + 64'd1);
        if (prod <= (128'(idx) << 1)) r = c;
      end
      tri_r = (128'(r) * 128'(r + 64'd1)) >> 1;
      res.index  = p;
      res.row    = r[OUT_BITS-1:0];
      res.column = OUT_BITS'(128'(idx) - tri_r);
      return res;
    endfunction

    task report(string what);
      $display("[%0t] mismatch: %s", $time, what);
      errors++;
    endtask

    function void note_index(logic [INDEX_BITS-1:0] p);
      expected_coords.push_back(split_index(p));
      indexes_seen++;
    endfunction

    task check_result(logic [OUT_BITS-1:0] row, logic [OUT_BITS-1:0] column);
      coord_t exp_c;
      if (expected_coords.size() == 0) begin
        report($sformatf("unexpected result row %0d column %0d", row, column));
      end else begin
        exp_c = expected_coords.pop_front();
        coords_checked++;
        if (row !== exp_c.row)
          report($sformatf("index %0d row %0d, expected %0d", exp_c.index, row, exp_c.row));
        if (column !== exp_c.column)
          report($sformatf("index %0d column %0d, expected %0d",
                           exp_c.index, column, exp_c.column));
      end
    endtask

    function int pending();
      return expected_coords.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [INDEX_BITS-1:0] in_packed_index;
  logic                  out_valid;
  logic                  out_ready;
  logic [OUT_BITS-1:0]   out_row;
  logic [OUT_BITS-1:0]   out_column;
  bit                    idle_enable;

  index_unpack_checker sb = new();

  triangular_index_unpack dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_packed_index (in_packed_index),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_row         (out_row),
    .out_column      (out_column)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("** triangular_index_unpack: FAILED **");
    $finish;
  end

  always @(negedge clk) begin
    out_ready <= idle_enable ? ($urandom_range(99) >= 23) : 1'b1;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) sb.note_index(in_packed_index);
      if (out_valid && out_ready) sb.check_result(out_row, out_column);
    end
  end

  function automatic logic [INDEX_BITS-1:0] tri_of(longint unsigned r);
    logic [127:0] t;
    t = (128'(r) * 128'(r + 1)) >> 1;
    if (t > 128'(INDEX_MAX)) return INDEX_MAX;
    return INDEX_BITS'(t);
  endfunction

  function automatic logic [INDEX_BITS-1:0] clamp_index(logic [127:0] v);
    if (v > 128'(INDEX_MAX)) return INDEX_MAX;
    return INDEX_BITS'(v);
  endfunction

  task automatic send_index(input logic [INDEX_BITS-1:0] p);
    @(negedge clk);
    while (idle_enable && $urandom_range(99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_packed_index <= p;
    do @(posedge clk); while (!in_ready);
  endtask

  function automatic logic [INDEX_BITS-1:0] random_index();
    longint unsigned       r;
    logic [INDEX_BITS-1:0] t;
    logic [63:0]           raw;
    raw = {$urandom, $urandom};
    case ($urandom_range(9))
      0, 1, 2, 3: return raw[INDEX_BITS-1:0];
      4, 5, 6: begin
        r = $urandom_range(1, 32'(ROW_MAX));
        t = tri_of(r);
        case ($urandom_range(3))
          0: return t - 1'b1;
          1: return t;
          2: return clamp_index(128'(t) + 128'(r));
          default: return clamp_index(128'(t) + 128'($urandom_range(0, 32'(r))));
        endcase
      end
      7: return INDEX_BITS'($urandom_range(0, 255));
      8: return raw[INDEX_BITS-1:0] >> $urandom_range(INDEX_BITS - 1);
      default: return INDEX_MAX - INDEX_BITS'($urandom_range(0, 100_000_000));
    endcase
  endfunction

  task automatic send_random(input int count);
    for (int k = 0; k < count; k++) send_index(random_index());
  endtask

  initial begin
    longint unsigned edge_rows[5];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_packed_index = '0;
    idle_enable = 1'b1;
    edge_rows = '{64'd1, 64'd2, 64'd1000, 64'd1048576, ROW_MAX};
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: zero, small rows, row boundaries, top of range, bit patterns
    for (int v = 0; v < 6; v++) send_index(INDEX_BITS'(v));
    foreach (edge_rows[k]) begin
      send_index(tri_of(edge_rows[k]) - 1'b1);
      send_index(tri_of(edge_rows[k]));
      send_index(clamp_index(128'(tri_of(edge_rows[k])) + 128'(edge_rows[k])));
    end
    send_index(INDEX_MAX);
    send_index(INDEX_MAX - 1'b1);
    send_index({1'b1, {(INDEX_BITS-1){1'b0}}});
    send_index({INDEX_BITS/2{2'b01}});
    send_index({INDEX_BITS/2{2'b10}});

    send_random(600);

    // hold off until the pipeline drains
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);

    idle_enable = 1'b0;
    send_random(400);
    idle_enable = 1'b1;
    send_random(700);

    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);

    if (sb.pending() != 0) sb.report($sformatf("%0d results never arrived", sb.pending()));
    $display("covered %0d packed indexes (zero, row edges, full range) under random stalls",
             sb.indexes_seen);
    $display("%0d row/column pairs compared, %0d mismatches", sb.coords_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("** triangular_index_unpack: PASSED **");
    end else begin
      $display("** triangular_index_unpack: FAILED **");
    end
    $finish;
  end

endmodule
